// ----- design/mkd_pkg.sv -----
package mkd_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int TICK_WIDTH_DEF   = 16;
    localparam int MAX_RESULTS      = 32;
    localparam int NRES_W           = $clog2(MAX_RESULTS + 1);

    localparam int LEVEL_W    = 10;
    localparam int PERIOD_W   = 16;
    localparam int GLITCH_W   = 8;
    localparam int CHAR_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 3;
    localparam int PAT_W      = 5;

    localparam logic [LEVEL_W-1:0]  LEVEL_THRESHOLD_RST = 10'd512;
    localparam logic [PERIOD_W-1:0] DOT_TICKS_RST       = 16'd100;
    localparam logic [PERIOD_W-1:0] DASH_TICKS_RST      = 16'd300;
    localparam logic [PERIOD_W-1:0] ELEM_PAUSE_RST      = 16'd100;
    localparam logic [PERIOD_W-1:0] LETTER_PAUSE_RST    = 16'd300;
    localparam logic [GLITCH_W-1:0] GLITCH_TICKS_RST    = 8'd10;

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd42;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_THRESHOLD = 3'd0,
        CFG_DOT_TICKS       = 3'd1,
        CFG_DASH_TICKS      = 3'd2,
        CFG_ELEM_PAUSE      = 3'd3,
        CFG_LETTER_PAUSE    = 3'd4,
        CFG_GLITCH_TICKS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp_res;

    // The pattern holds the code left to right in its low len bits, dash = 1.
    function automatic logic [CHAR_W-1:0] f_morse_lookup(input logic [LEN_W-1:0] len,
                                                         input logic [PAT_W-1:0] pat);
        logic [CHAR_W-1:0] ch;
        ch = CHAR_UNKNOWN;
        case (len)
            3'd1: begin
                case (pat)
                    5'b00000: ch = 7'h45;
                    5'b00001: ch = 7'h54;
                    default:  ch = CHAR_UNKNOWN;
                endcase
            end
            3'd2: begin
                case (pat)
                    5'b00000: ch = 7'h49;
                    5'b00001: ch = 7'h41;
                    5'b00010: ch = 7'h4E;
                    5'b00011: ch = 7'h4D;
                    default:  ch = CHAR_UNKNOWN;
                endcase
            end
            3'd3: begin
                case (pat)
                    5'b00000: ch = 7'h53;
                    5'b00001: ch = 7'h55;
                    5'b00010: ch = 7'h52;
                    5'b00011: ch = 7'h57;
                    5'b00100: ch = 7'h44;
                    5'b00101: ch = 7'h4B;
                    5'b00110: ch = 7'h47;
                    5'b00111: ch = 7'h4F;
                    default:  ch = CHAR_UNKNOWN;
                endcase
            end
            3'd4: begin
                case (pat)
                    5'b00000: ch = 7'h48;
                    5'b00001: ch = 7'h56;
                    5'b00010: ch = 7'h46;
                    5'b00100: ch = 7'h4C;
                    5'b00110: ch = 7'h50;
                    5'b00111: ch = 7'h4A;
                    5'b01000: ch = 7'h42;
                    5'b01001: ch = 7'h58;
                    5'b01010: ch = 7'h43;
                    5'b01011: ch = 7'h59;
                    5'b01100: ch = 7'h5A;
                    5'b01101: ch = 7'h51;
                    default:  ch = CHAR_UNKNOWN;
                endcase
            end
            3'd5: begin
                case (pat)
                    5'b00000: ch = 7'h35;
                    5'b00001: ch = 7'h34;
                    5'b00011: ch = 7'h33;
                    5'b00111: ch = 7'h32;
                    5'b01111: ch = 7'h31;
                    5'b11111: ch = 7'h30;
                    5'b10000: ch = 7'h36;
                    5'b11000: ch = 7'h37;
                    5'b11100: ch = 7'h38;
                    5'b11110: ch = 7'h39;
                    default:  ch = CHAR_UNKNOWN;
                endcase
            end
            default: ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/mkd_in_if.sv -----
interface mkd_in_if import mkd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] key_level;

    modport source (output valid, output key_level, input ready);
    modport sink (input valid, input key_level, output ready);
endinterface

// ----- design/mkd_out_if.sv -----
interface mkd_out_if import mkd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- design/mkd_ram.sv -----
module mkd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/mkd_cmp.sv -----
module mkd_cmp import mkd_pkg::*; #(
    parameter int W = 17
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_cmp_res     o_res
);
    t_cmp_res r_res;
    t_cmp_res n_res;

    always_comb begin
        n_res.lt = i_a < i_b;
        n_res.gt = i_a > i_b;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;
endmodule

// ----- design/morse_key_timing_decoder_core.sv -----
// Morse key decoder: one key-level sample is requested per tick. When the silence
// passes twice the mean pause, the stored word is walked entry by entry through
// the interval memory's single read port and the one shared comparator; the
// input is not ready meanwhile.
// Characters leave through an output register one request at a time, the last
// character of a word carrying last_char; a key held past the word limit
// discards the stored word without any output.
module morse_key_timing_decoder_core import mkd_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int TICK_WIDTH   = TICK_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mkd_in_if.sink                i_in,
    mkd_out_if.source             o_out
);
    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int EW    = TICK_WIDTH + 1;
    localparam int CMP_W = (TICK_WIDTH > PERIOD_W + 1) ? TICK_WIDTH : PERIOD_W + 1;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_GCMP  = 10'b0000000010,
        S_EDGE  = 10'b0000000100,
        S_WCMP  = 10'b0000001000,
        S_WCHK  = 10'b0000010000,
        S_RD    = 10'b0000100000,
        S_CLS   = 10'b0001000000,
        S_ACC   = 10'b0010000000,
        S_CHAR  = 10'b0100000000,
        S_FLUSH = 10'b1000000000
    } t_state;

    t_state                r_state;
    logic [LEVEL_W-1:0]    r_level_thr;
    logic [PERIOD_W-1:0]   r_dot;
    logic [PERIOD_W-1:0]   r_dash;
    logic [PERIOD_W-1:0]   r_epause;
    logic [PERIOD_W-1:0]   r_lpause;
    logic [GLITCH_W-1:0]   r_glitch;
    logic [TICK_WIDTH-1:0] r_ticks;
    logic                  r_key;
    logic [CNT_W-1:0]      r_count;
    logic [TICK_WIDTH-1:0] r_interval;
    logic                  r_press;
    logic [CNT_W-1:0]      r_pos;
    logic [NRES_W-1:0]     r_nres;
    logic [LEN_W-1:0]      r_len;
    logic [PAT_W-1:0]      r_pat;
    logic [CHAR_W-1:0]     r_pend;
    logic                  r_have_pend;
    logic                  r_kind;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_code;
    logic                  r_out_last;

    logic [TICK_WIDTH-1:0] n_ticks;
    logic [PERIOD_W:0]     pip_sum;
    logic [PERIOD_W:0]     pause_sum;
    logic [PERIOD_W-1:0]   mean_pip;
    logic [PERIOD_W-1:0]   mean_pause;
    logic [PERIOD_W:0]     word_limit;
    logic [CMP_W-1:0]      cmp_a;
    logic [CMP_W-1:0]      cmp_b;
    t_cmp_res              cmp_res;
    logic                  ram_we;
    logic [EW-1:0]         ram_rdata;
    logic                  can_load;
    logic                  accept;
    logic                  pressed;
    logic [CHAR_W-1:0]     char_now;

    assign accept    = i_in.valid && i_in.ready;
    assign pressed   = i_in.key_level < r_level_thr;
    assign n_ticks   = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 1'b1;
    assign pip_sum   = {1'b0, r_dot} + {1'b0, r_dash};
    assign pause_sum = {1'b0, r_epause} + {1'b0, r_lpause};
    assign mean_pip  = pip_sum[PERIOD_W:1];
    assign mean_pause = pause_sum[PERIOD_W:1];
    assign word_limit = {pause_sum[PERIOD_W:1], 1'b0};
    assign can_load  = !r_out_valid || o_out.ready;
    assign char_now  = f_morse_lookup(r_len, r_pat);
    assign ram_we    = (r_state == S_EDGE) && !cmp_res.lt && !(r_press && r_count == '0)
                       && (r_count < CNT_W'(BUFFER_DEPTH));

    // Operand selection for the single comparator; its registered result is read in the cycle after.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (r_state)
            S_GCMP: begin
                cmp_a = CMP_W'(r_interval);
                cmp_b = CMP_W'(r_glitch);
            end
            S_WCMP: begin
                cmp_a = CMP_W'(r_interval);
                cmp_b = CMP_W'(word_limit);
            end
            S_CLS: begin
                cmp_a = CMP_W'(ram_rdata[TICK_WIDTH-1:0]);
                cmp_b = ram_rdata[TICK_WIDTH] ? CMP_W'(mean_pip) : CMP_W'(mean_pause);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    mkd_cmp #(.W(CMP_W)) u_cmp (
        .i_clk (i_clk),
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    mkd_ram #(.WIDTH(EW), .DEPTH(BUFFER_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({~r_press, r_interval}),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_thr <= LEVEL_THRESHOLD_RST;
            r_dot       <= DOT_TICKS_RST;
            r_dash      <= DASH_TICKS_RST;
            r_epause    <= ELEM_PAUSE_RST;
            r_lpause    <= LETTER_PAUSE_RST;
            r_glitch    <= GLITCH_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEVEL_THRESHOLD: r_level_thr <= i_cfg_data[LEVEL_W-1:0];
                CFG_DOT_TICKS:       r_dot       <= i_cfg_data[PERIOD_W-1:0];
                CFG_DASH_TICKS:      r_dash      <= i_cfg_data[PERIOD_W-1:0];
                CFG_ELEM_PAUSE:      r_epause    <= i_cfg_data[PERIOD_W-1:0];
                CFG_LETTER_PAUSE:    r_lpause    <= i_cfg_data[PERIOD_W-1:0];
                CFG_GLITCH_TICKS:    r_glitch    <= i_cfg_data[GLITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticks     <= '0;
            r_key       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_interval <= n_ticks;
                        r_ticks    <= n_ticks;
                        r_press    <= pressed;
                        r_state    <= (pressed != r_key) ? S_GCMP : S_WCMP;
                    end
                end
                S_GCMP: begin
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    if (cmp_res.lt) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_key   <= r_press;
                        r_ticks <= '0;
                        // A press on an empty store drops the leading pause.
                        if (r_press && r_count == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (ram_we) begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_WCMP;
                        end
                    end
                end
                S_WCMP: begin
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (!cmp_res.gt) begin
                        r_state <= S_IDLE;
                    end else if (r_key) begin
                        r_ticks <= '0;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else if (r_count == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos       <= '0;
                        r_nres      <= '0;
                        r_len       <= '0;
                        r_pat       <= '0;
                        r_have_pend <= 1'b0;
                        r_state     <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CLS;
                end
                S_CLS: begin
                    r_kind  <= ram_rdata[TICK_WIDTH];
                    r_pos   <= r_pos + 1'b1;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_kind) begin
                        if (r_len < LEN_W'(PAT_W)) begin
                            r_pat <= {r_pat[PAT_W-2:0], !cmp_res.lt};
                        end
                        if (r_len <= LEN_W'(PAT_W)) begin
                            r_len <= r_len + 1'b1;
                        end
                    end
                    if ((!r_kind && cmp_res.gt) || r_pos >= r_count) begin
                        r_state <= S_CHAR;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_CHAR: begin
                    // A character without marks ends the word.
                    if (r_len == '0) begin
                        r_state <= r_have_pend ? S_FLUSH : S_IDLE;
                        if (!r_have_pend) begin
                            r_count <= '0;
                        end
                    end else if (!r_have_pend || can_load) begin
                        if (r_have_pend) begin
                            r_out_valid <= 1'b1;
                            r_out_code  <= r_pend;
                            r_out_last  <= 1'b0;
                        end
                        r_pend      <= char_now;
                        r_have_pend <= 1'b1;
                        r_nres      <= r_nres + 1'b1;
                        r_len       <= '0;
                        r_pat       <= '0;
                        if (r_nres == NRES_W'(MAX_RESULTS - 1) || r_pos >= r_count) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_FLUSH: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_code  <= r_pend;
                        r_out_last  <= 1'b1;
                        r_have_pend <= 1'b0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_code;
    assign o_out.last_char = r_out_last;
endmodule

// ----- design/mkd_checker.sv -----
module mkd_checker import mkd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_out_code,
    input logic              i_out_last
);
    // Every sample starts a multi-cycle sequence, so the input cannot be ready right after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted sample");

    // Characters are only produced during a word walk, never from the idle state.
    a_out_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("character produced while the block was idle");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_code) && $stable(i_out_last)))
        else $error("stalled character changed");
endmodule

bind morse_key_timing_decoder_core mkd_checker u_mkd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_code  (o_out.char_code),
    .i_out_last  (o_out.last_char)
);

// ----- tb/tb_morse_key_timing_decoder_core.sv -----
module tb_morse_key_timing_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mkd_pkg::*;

    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD_OFF  = 600;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_t;

    // Tracks the decoder state per key sample and keeps the characters it owes.
    class morse_checker;
        logic [LEVEL_W-1:0]        threshold;
        logic [PERIOD_W-1:0]       dot_len;
        logic [PERIOD_W-1:0]       dash_len;
        logic [PERIOD_W-1:0]       elem_gap;
        logic [PERIOD_W-1:0]       letter_gap;
        logic [GLITCH_W-1:0]       glitch_len;
        logic [TICK_WIDTH_DEF-1:0] since_edge;
        logic                      key_down;
        logic [TICK_WIDTH_DEF:0]   intervals [BUFFER_DEPTH_DEF];
        int unsigned               stored;
        char_t                     expected_chars [$];
        int                        mismatches;
        int                        produced;

        function new();
            threshold  = LEVEL_THRESHOLD_RST;
            dot_len    = DOT_TICKS_RST;
            dash_len   = DASH_TICKS_RST;
            elem_gap   = ELEM_PAUSE_RST;
            letter_gap = LETTER_PAUSE_RST;
            glitch_len = GLITCH_TICKS_RST;
            since_edge = '0;
            key_down   = 1'b0;
            stored     = 0;
            mismatches = 0;
            produced   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LEVEL_THRESHOLD: threshold  = val[LEVEL_W-1:0];
                CFG_DOT_TICKS:       dot_len    = val[PERIOD_W-1:0];
                CFG_DASH_TICKS:      dash_len   = val[PERIOD_W-1:0];
                CFG_ELEM_PAUSE:      elem_gap   = val[PERIOD_W-1:0];
                CFG_LETTER_PAUSE:    letter_gap = val[PERIOD_W-1:0];
                CFG_GLITCH_TICKS:    glitch_len = val[GLITCH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned word_limit();
            return (32'(elem_gap) + 32'(letter_gap)) / 2 * 2;
        endfunction

        function logic [CHAR_W-1:0] morse_char(string pat);
            byte ch;
            ch = 8'(CHAR_UNKNOWN);
            case (pat)
                ".-":    ch = "A";
                "-...":  ch = "B";
                "-.-.":  ch = "C";
                "-..":   ch = "D";
                ".":     ch = "E";
                "..-.":  ch = "F";
                "--.":   ch = "G";
                "....":  ch = "H";
                "..":    ch = "I";
                ".---":  ch = "J";
                "-.-":   ch = "K";
                ".-..":  ch = "L";
                "--":    ch = "M";
                "-.":    ch = "N";
                "---":   ch = "O";
                ".--.":  ch = "P";
                "--.-":  ch = "Q";
                ".-.":   ch = "R";
                "...":   ch = "S";
                "-":     ch = "T";
                "..-":   ch = "U";
                "...-":  ch = "V";
                ".--":   ch = "W";
                "-..-":  ch = "X";
                "-.--":  ch = "Y";
                "--..":  ch = "Z";
                "-----": ch = "0";
                ".----": ch = "1";
                "..---": ch = "2";
                "...--": ch = "3";
                "....-": ch = "4";
                ".....": ch = "5";
                "-....": ch = "6";
                "--...": ch = "7";
                "---..": ch = "8";
                "----.": ch = "9";
                default: ch = 8'(CHAR_UNKNOWN);
            endcase
            return ch[CHAR_W-1:0];
        endfunction

        // Marks are classified against the timing in force when the word ends.
        function void decode_word();
            int unsigned             mean_mark;
            int unsigned             mean_gap;
            int unsigned             pos;
            int unsigned             len;
            string                   pat;
            logic [TICK_WIDTH_DEF:0] e;
            char_t                   word [$];
            char_t                   ch;
            mean_mark = (32'(dot_len) + 32'(dash_len)) / 2;
            mean_gap  = (32'(elem_gap) + 32'(letter_gap)) / 2;
            pos = 0;
            while (pos < stored && word.size() < MAX_RESULTS) begin
                pat = "";
                len = 0;
                forever begin
                    e = intervals[pos];
                    pos++;
                    if (e[TICK_WIDTH_DEF]) begin
                        if (len < 8) begin
                            if (e[TICK_WIDTH_DEF-1:0] < mean_mark) pat = {pat, "."};
                            else pat = {pat, "-"};
                        end
                        if (len < 255) len++;
                    end else if (e[TICK_WIDTH_DEF-1:0] > mean_gap) begin
                        break;
                    end
                    if (pos >= stored) break;
                end
                if (len == 0) break;
                ch.code = (len > 5) ? CHAR_UNKNOWN : morse_char(pat);
                ch.last = 1'b0;
                word.push_back(ch);
            end
            if (word.size() > 0) word[word.size()-1].last = 1'b1;
            foreach (word[i]) expected_chars.push_back(word[i]);
            produced += word.size();
        endfunction

        function void note_sample(logic [LEVEL_W-1:0] level);
            logic        down;
            int unsigned span;
            down = (level < threshold);
            if (since_edge != '1) since_edge++;
            span = since_edge;
            if (down != key_down) begin
                if (span < glitch_len) return;
                key_down   = down;
                since_edge = '0;
                // The pause before the first press of a word is never stored.
                if (down && stored == 0) return;
                if (stored < BUFFER_DEPTH_DEF) begin
                    intervals[stored] = {~down, span[TICK_WIDTH_DEF-1:0]};
                    stored++;
                end
            end
            if (span > word_limit()) begin
                if (key_down) begin
                    since_edge = '0;
                    stored     = 0;
                    return;
                end
                if (stored == 0) return;
                decode_word();
                stored = 0;
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            char_t want;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got %h last %b",
                         $time, code, last);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (code !== want.code) begin
                $display("%0t: char_code mismatch: expected %h, got %h",
                         $time, want.code, code);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last_char mismatch: expected %b, got %b",
                         $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mkd_in_if  key_if ();
    mkd_out_if char_if ();

    morse_checker sb = new();
    bit           calm = 1'b0;
    bit           hold_off_req = 1'b0;
    int           samples_sent = 0;
    int           quiet_cycles = 0;
    int           rx_wait = 0;

    morse_key_timing_decoder_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (key_if),
        .o_out      (char_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LEVEL_W-1:0] level_for(bit down);
        int unsigned thr;
        int unsigned r;
        thr = sb.threshold;
        r = $urandom_range(0, 19);
        if (down && thr != 0) begin
            if (r == 0) return '0;
            if (r == 1) return LEVEL_W'(thr - 1);
            return LEVEL_W'($urandom_range(0, thr - 1));
        end
        if (r == 0) return '1;
        if (r == 1) return LEVEL_W'(thr);
        return LEVEL_W'($urandom_range(thr, 1023));
    endfunction

    function automatic int stretch(int unsigned nom, bit rough);
        int unsigned spread;
        if (rough) return $urandom_range(1, 2 * nom + 1);
        spread = nom / 3;
        return nom - spread + $urandom_range(0, 2 * spread);
    endfunction

    function automatic string random_pattern();
        string       pat;
        int unsigned r;
        int unsigned len;
        int unsigned nchars;
        pat = "";
        nchars = $urandom_range(1, 6);
        for (int c = 0; c < nchars; c++) begin
            if (c > 0) pat = {pat, " "};
            r = $urandom_range(0, 19);
            len = (r < 16) ? $urandom_range(1, 4) : (r < 19) ? 5 : $urandom_range(6, 7);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 1)) pat = {pat, "-"};
                else pat = {pat, "."};
            end
        end
        return pat;
    endfunction

    // Valid stays high after a request is taken, so back-to-back samples never
    // drop it within one step.
    task automatic send_sample(input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_if.valid     <= 1'b1;
        key_if.key_level <= lvl;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        sb.note_sample(lvl);
        samples_sent++;
    endtask

    task automatic hold_key(input bit down, input int n);
        repeat (n) send_sample(level_for(down));
    endtask

    task automatic drain();
        key_if.valid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] dot,
                              input logic [CFG_DATA_W-1:0] dash,
                              input logic [CFG_DATA_W-1:0] elem,
                              input logic [CFG_DATA_W-1:0] letter,
                              input logic [CFG_DATA_W-1:0] glitch);
        write_cfg(CFG_LEVEL_THRESHOLD, thr);
        write_cfg(CFG_DOT_TICKS, dot);
        write_cfg(CFG_DASH_TICKS, dash);
        write_cfg(CFG_ELEM_PAUSE, elem);
        write_cfg(CFG_LETTER_PAUSE, letter);
        write_cfg(CFG_GLITCH_TICKS, glitch);
    endtask

    // Spaces in the pattern are letter pauses; the word is closed by a silence.
    task automatic send_pattern(input string pat, input bit rough);
        int unsigned len;
        if (rough && $urandom_range(0, 3) == 0) begin
            hold_key(1'b1, stretch(sb.dot_len, 1'b0));
            hold_key(1'b0, stretch(sb.elem_gap, 1'b0));
            hold_key(1'b1, sb.word_limit() + 3);
            hold_key(1'b0, stretch(sb.letter_gap, 1'b0));
        end
        for (int i = 0; i < pat.len(); i++) begin
            if (pat[i] == " ") continue;
            len = (pat[i] == "-") ? sb.dash_len : sb.dot_len;
            hold_key(1'b1, stretch(len, rough));
            if (rough && $urandom_range(0, 9) == 0) begin
                send_sample(level_for(1'b0));
                hold_key(1'b1, stretch(sb.dot_len, rough));
            end
            if (i + 1 < pat.len()) begin
                len = (pat[i+1] == " ") ? sb.letter_gap : sb.elem_gap;
                hold_key(1'b0, stretch(len, rough));
            end
        end
        hold_key(1'b0, sb.word_limit() + 2 + $urandom_range(0, 4));
    endtask

    // Receiver: checks every taken character and stalls at random.
    initial begin
        int gap;
        char_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (char_if.valid && char_if.ready)
                sb.check_char(char_if.char_code, char_if.last_char);
            if (!i_rst_n) begin
                char_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                char_if.ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                rx_wait = LONG_HOLD_OFF - 1;
                char_if.ready <= 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    rx_wait = gap - 1;
                    char_if.ready <= 1'b0;
                end else begin
                    char_if.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((key_if.valid && key_if.ready) || (char_if.valid && char_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("tb_morse_key_timing_decoder_core: errors");
                $finish;
            end
        end
    end

    initial begin
        int phase_start;
        int made;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_LEVEL_THRESHOLD;
        i_cfg_data       <= '0;
        key_if.valid     <= 1'b0;
        key_if.key_level <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: one dot at nominal length, with levels at the threshold
        // boundary. The first presses land inside the glitch window after reset.
        send_sample(10'd1023);
        send_sample(10'd512);
        send_sample(10'd0);
        hold_key(1'b1, 98);
        send_sample(10'd511);
        send_sample(10'd512);
        hold_key(1'b0, 410);
        drain();

        set_timing(16'd300, 16'd3, 16'd9, 16'd3, 16'd9, 16'd2);
        send_pattern("...... -.-.-.", 1'b0);
        send_pattern(".- ..-- -----", 1'b0);
        send_pattern("....- --.. .", 1'b0);
        // A flip right after an edge is ignored as a glitch.
        hold_key(1'b1, 1);
        hold_key(1'b0, 1);
        hold_key(1'b1, 3);
        hold_key(1'b0, sb.word_limit() + 3);
        // A key held past the word limit throws the partial word away.
        hold_key(1'b1, 3);
        hold_key(1'b0, 3);
        hold_key(1'b1, sb.word_limit() + 4);
        hold_key(1'b0, sb.word_limit() + 3);
        drain();

        // With a zero threshold the key can never be pressed.
        write_cfg(CFG_LEVEL_THRESHOLD, 16'd0);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd511);
        drain();

        set_timing(16'($urandom_range(200, 800)), 16'd3, 16'd9, 16'd3, 16'd9, 16'd2);
        phase_start = samples_sent;
        made = sb.produced;
        while (samples_sent - phase_start < 250 || sb.produced - made < 30) begin
            calm = ($urandom_range(0, 3) == 0);
            send_pattern(random_pattern(), $urandom_range(0, 4) == 0);
        end
        calm = 1'b0;

        // More characters than the store holds, with the receiver held off so
        // that the decoder backs up into its input.
        repeat (40) begin
            hold_key(1'b1, 3);
            hold_key(1'b0, 9);
        end
        hold_off_req = 1'b1;
        hold_key(1'b0, sb.word_limit() + 60);
        drain();

        // Odd sums for the means; unused upper data bits are set.
        set_timing({6'h2A, 10'($urandom_range(100, 900))}, 16'd2, 16'd5, 16'd2, 16'd5,
                   {8'hC5, 8'd1});
        phase_start = samples_sent;
        made = sb.produced;
        while (samples_sent - phase_start < 150 || sb.produced - made < 10)
            send_pattern(random_pattern(), $urandom_range(0, 4) == 0);
        drain();

        // Shortest timing, no glitch filter: random key noise decodes constantly.
        set_timing(16'd1023, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        phase_start = samples_sent;
        while (samples_sent - phase_start < 160)
            hold_key($urandom_range(0, 1), $urandom_range(1, 4));
        hold_key(1'b0, 5);
        drain();

        // Longest timing: a mark held past the tick counter's range saturates.
        set_timing(16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
        calm = 1'b1;
        hold_key(1'b0, 300);
        hold_key(1'b1, 65600);
        hold_key(1'b0, 300);
        hold_key(1'b1, 300);
        hold_key(1'b0, 5);
        drain();
        write_cfg(CFG_ELEM_PAUSE, 16'd1);
        write_cfg(CFG_LETTER_PAUSE, 16'd1);
        hold_key(1'b0, 5);
        calm = 1'b0;

        key_if.valid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_morse_key_timing_decoder_core: clean");
        end else begin
            $display("tb_morse_key_timing_decoder_core: errors");
        end
        $finish;
    end

endmodule
